FILE: sv/dct_pkg.sv
// ----------------------------------------------------------------------------
// dct_pkg: shared types and constants of the delimiter class tokenizer
// Action and result codes, class bit positions, the queue item and the
// result push bundle used between the front, the back and the result buffer.
// ----------------------------------------------------------------------------
package dct_pkg;

  // default counter widths
  localparam int LINE_COUNT_BITS_DEF  = 20;
  localparam int TOKEN_COUNT_BITS_DEF = 10;

  // input action codes
  typedef enum logic [1:0] {
    ACT_TEXT     = 2'd0,
    ACT_EOI      = 2'd1,
    ACT_OR_CLASS = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_t;

  // result kinds
  localparam logic [1:0] KIND_TOKEN = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EOI   = 2'd2;

  // class bit positions
  localparam int CL_TERM  = 0;
  localparam int CL_SKIP  = 1;
  localparam int CL_COMM  = 2;
  localparam int CL_QUOTE = 3;

  // special bytes
  localparam logic [7:0] CH_NUL = 8'd0;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;

  // front to back queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // result buffer
  localparam int RDEPTH    = 4;
  localparam int RPTR_W    = $clog2(RDEPTH);
  localparam int RCNT_W    = $clog2(RDEPTH + 1);
  localparam int MAX_PUSH  = 3;

  // one classified item for the back
  typedef struct packed {
    logic       eoi;
    logic [7:0] data;
    logic [3:0] cls;
  } item_t;

  // fixed part of one result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } res_t;

  // results made by one item
  typedef struct packed {
    logic [1:0]       count;
    res_t [2:0]       slot;
  } push_t;

  // class entry value after a table clear
  function automatic logic [3:0] class_reset(input logic [7:0] idx);
    class_reset = (idx == CH_NUL) ? 4'b0001 : 4'b0000;
  endfunction

endpackage

FILE: sv/dct_front.sv
// ----------------------------------------------------------------------------
// dct_front: input acceptance and class lookup
// Holds the 256-entry class table, applies table writes and clears, and
// hands text bytes and end-of-input items with their class to the queue.
// ----------------------------------------------------------------------------
module dct_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_data_byte,
  input  logic [3:0]         in_class_bits,
  output logic               q_push,
  output dct_pkg::item_t     q_item,
  input  logic               q_full
);

  logic [3:0]   cls_mem [256];
  logic [255:0] tbl_vld_r;
  logic         s1_v_r;
  logic         s1_eoi_r;
  logic [7:0]   s1_byte_r;
  logic [3:0]   rd_r;
  logic         rdv_r;

  logic         accept;
  logic         ld;
  logic         tbl_we;
  logic         tbl_clr;
  logic [3:0]   wmask;
  logic [3:0]   wdata;
  logic         s1_v_nxt;

  // handshake and action decode
  assign in_stall = s1_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = s1_v_r && !q_full;

  always_comb begin
    ld      = 1'b0;
    tbl_we  = 1'b0;
    tbl_clr = 1'b0;
    if (accept) begin
      unique case (dct_pkg::action_t'(in_action))
        dct_pkg::ACT_TEXT:     ld      = 1'b1;
        dct_pkg::ACT_EOI:      ld      = 1'b1;
        dct_pkg::ACT_OR_CLASS: tbl_we  = 1'b1;
        dct_pkg::ACT_CLEAR:    tbl_clr = 1'b1;
        default:               ld      = 1'b0;
      endcase
    end
  end

  // an entry not yet written since clear takes its clear value plus the new bits
  always_comb begin
    if (tbl_vld_r[in_data_byte]) begin
      wmask = in_class_bits;
      wdata = 4'hF;
    end else begin
      wmask = 4'hF;
      wdata = dct_pkg::class_reset(in_data_byte) | in_class_bits;
    end
  end

  // class table storage with per-bit write and registered read
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      for (int k = 0; k < 4; k++) begin
        if (wmask[k]) cls_mem[in_data_byte][k] <= wdata[k];
      end
    end
    if (ld) begin
      rd_r <= cls_mem[in_data_byte];
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
    end else if (tbl_clr) begin
      tbl_vld_r <= '0;
    end else if (tbl_we) begin
      tbl_vld_r[in_data_byte] <= 1'b1;
    end
  end

  // lookup stage
  always_comb begin
    if (accept) s1_v_nxt = ld;
    else if (q_push) s1_v_nxt = 1'b0;
    else s1_v_nxt = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
    if (ld) begin
      s1_eoi_r  <= (in_action == dct_pkg::ACT_EOI);
      s1_byte_r <= in_data_byte;
      rdv_r     <= tbl_vld_r[in_data_byte];
    end
  end

  // classified item
  assign q_item.eoi  = s1_eoi_r;
  assign q_item.data = s1_byte_r;
  assign q_item.cls  = rdv_r ? rd_r : dct_pkg::class_reset(s1_byte_r);

endmodule

FILE: sv/dct_queue.sv
// ----------------------------------------------------------------------------
// dct_queue: short item queue between front and back
// A small register queue so that the lookup and the tokenizer stall apart.
// ----------------------------------------------------------------------------
module dct_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dct_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           pop_valid,
  output dct_pkg::item_t pop_item
);

  dct_pkg::item_t               ent_r [dct_pkg::QDEPTH];
  logic [dct_pkg::QPTR_W-1:0]   wp_r;
  logic [dct_pkg::QPTR_W-1:0]   rp_r;
  logic [dct_pkg::QCNT_W-1:0]   cnt_r;
  logic [dct_pkg::QCNT_W-1:0]   cnt_nxt;

  assign full      = (cnt_r == dct_pkg::QCNT_W'(dct_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = ent_r[rp_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && pop_valid)) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop && pop_valid) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop && pop_valid) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
    if (push) ent_r[wp_r] <= push_item;
  end

endmodule

FILE: sv/dct_back.sv
// ----------------------------------------------------------------------------
// dct_back: line and token stages
// Folds line ends, drops comment tails, tracks quotes and cuts tokens,
// making up to three results for each item it takes.
// ----------------------------------------------------------------------------
module dct_back #(
  parameter int LINE_COUNT_BITS  = dct_pkg::LINE_COUNT_BITS_DEF,
  parameter int TOKEN_COUNT_BITS = dct_pkg::TOKEN_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  dct_pkg::item_t              q_item,
  input  logic                        space_ok,
  output logic                        q_pop,
  output dct_pkg::push_t              push,
  output logic [LINE_COUNT_BITS-1:0]  res_line,
  output logic [TOKEN_COUNT_BITS-1:0] res_index
);

  typedef enum logic [1:0] {
    LEM_NORMAL   = 2'd0,
    LEM_AFTER_CR = 2'd1,
    LEM_FLUSH    = 2'd2
  } lem_t;

  localparam logic [LINE_COUNT_BITS-1:0]  LINE_SAT  = {LINE_COUNT_BITS{1'b1}};
  localparam logic [TOKEN_COUNT_BITS-1:0] TOKEN_SAT = {TOKEN_COUNT_BITS{1'b1}};

  lem_t                        lem_r, lem_nxt;
  logic [7:0]                  lq_r, lq_nxt;
  logic [LINE_COUNT_BITS-1:0]  lc_r, lc_nxt;
  logic                        lne_r, lne_nxt;
  logic [7:0]                  tq_r, tq_nxt;
  logic                        ts_r, ts_nxt;
  logic                        hv_r, hv_nxt;
  logic [7:0]                  hc_r, hc_nxt;
  logic [TOKEN_COUNT_BITS-1:0] tc_r, tc_nxt;

  logic fire;

  assign fire  = q_valid && space_ok;
  assign q_pop = fire;

  // per-item line and token update
  always_comb begin
    logic [7:0]       b;
    logic [3:0]       cl;
    logic             drop;
    logic             lf_unc;
    logic             end_line;
    logic             count;
    logic             finish;
    logic             store;
    logic [1:0]       n;
    dct_pkg::res_t [3:0] sl;

    lem_nxt   = lem_r;
    lq_nxt    = lq_r;
    lc_nxt    = lc_r;
    lne_nxt   = lne_r;
    tq_nxt    = tq_r;
    ts_nxt    = ts_r;
    hv_nxt    = hv_r;
    hc_nxt    = hc_r;
    tc_nxt    = tc_r;
    b         = q_item.data;
    cl        = q_item.cls;
    drop      = 1'b0;
    lf_unc    = 1'b0;
    end_line  = 1'b0;
    count     = 1'b0;
    finish    = 1'b0;
    store     = 1'b0;
    n         = 2'd0;
    sl        = '0;
    res_index = tc_r;
    res_line  = lc_r;

    if (fire) begin
      if (q_item.eoi) begin
        // end of input: finish a line with content, then report
        if (lne_r) begin
          if (lem_r == LEM_AFTER_CR) lem_nxt = LEM_NORMAL;
          finish = 1'b1;
        end
      end else if (lem_r == LEM_FLUSH) begin
        // comment tail: drop until a line end
        if (b == dct_pkg::CH_CR) lem_nxt = LEM_AFTER_CR;
        else if (b == dct_pkg::CH_LF) lem_nxt = LEM_NORMAL;
      end else begin
        if (lem_r == LEM_AFTER_CR && b == dct_pkg::CH_LF) begin
          if (lq_r == 8'd0) drop = 1'b1;
          else lf_unc = 1'b1;
        end
        lem_nxt = LEM_NORMAL;
        if (!drop) begin
          // line end detection
          priority if (b == dct_pkg::CH_NUL) begin
            end_line = 1'b1;
          end else if (b == dct_pkg::CH_CR) begin
            count    = 1'b1;
            lem_nxt  = LEM_AFTER_CR;
            end_line = (lq_r == 8'd0);
          end else if (lq_r == 8'd0 && cl[dct_pkg::CL_COMM]) begin
            count    = 1'b1;
            lem_nxt  = LEM_FLUSH;
            end_line = 1'b1;
          end else if (b == dct_pkg::CH_LF) begin
            count    = !lf_unc;
            end_line = (lq_r == 8'd0);
          end else begin
            end_line = 1'b0;
          end
          if (count && lc_r != LINE_SAT) lc_nxt = lc_r + 1'b1;
          res_line = lc_nxt;

          if (end_line) begin
            finish = 1'b1;
          end else begin
            // line quote tracking
            if (cl[dct_pkg::CL_QUOTE]) begin
              if (lq_r == 8'd0) lq_nxt = b;
              else if (b == lq_r) lq_nxt = 8'd0;
            end
            lne_nxt = 1'b1;

            // token quote tracking
            if (cl[dct_pkg::CL_QUOTE]) begin
              if (tq_r == 8'd0) tq_nxt = b;
              else if (b == tq_r) tq_nxt = 8'd0;
            end
            store = !cl[dct_pkg::CL_SKIP] || (tq_nxt != 8'd0 && tq_nxt != b);

            // keep the character, sending out the one held before it
            if (store) begin
              if (!ts_r) begin
                ts_nxt = 1'b1;
                if (tc_r != TOKEN_SAT) tc_nxt = tc_r + 1'b1;
              end
              if (hv_r) begin
                sl[n] = '{kind: dct_pkg::KIND_TOKEN, ch: hc_r, last: 1'b0};
                n     = n + 2'd1;
              end
              hc_nxt = b;
              hv_nxt = 1'b1;
            end

            // terminator closes the token
            if (tq_nxt == 8'd0 && ts_nxt && cl[dct_pkg::CL_TERM]) begin
              if (hv_nxt) begin
                sl[n] = '{kind: dct_pkg::KIND_TOKEN, ch: hc_nxt, last: 1'b1};
                n     = n + 2'd1;
              end
              hv_nxt = 1'b0;
              ts_nxt = 1'b0;
            end
            res_index = tc_nxt;
          end
        end
      end

      // line finish: flush held character and report the line end
      if (finish) begin
        if (hv_r) begin
          sl[n] = '{kind: dct_pkg::KIND_TOKEN, ch: hc_r, last: 1'b1};
          n     = n + 2'd1;
        end
        sl[n]   = '{kind: dct_pkg::KIND_LINE, ch: 8'd0, last: 1'b0};
        n       = n + 2'd1;
        hv_nxt  = 1'b0;
        ts_nxt  = 1'b0;
        tq_nxt  = 8'd0;
        tc_nxt  = '0;
        lq_nxt  = 8'd0;
        lne_nxt = 1'b0;
      end

      if (q_item.eoi) begin
        sl[n]  = '{kind: dct_pkg::KIND_EOI, ch: 8'd0, last: 1'b0};
        n      = n + 2'd1;
        lc_nxt = '0;
      end
    end

    push.count = n;
    push.slot  = sl[2:0];
  end

  // state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lem_r <= LEM_NORMAL;
      lq_r  <= 8'd0;
      lc_r  <= '0;
      lne_r <= 1'b0;
      tq_r  <= 8'd0;
      ts_r  <= 1'b0;
      hv_r  <= 1'b0;
      hc_r  <= 8'd0;
      tc_r  <= '0;
    end else begin
      lem_r <= lem_nxt;
      lq_r  <= lq_nxt;
      lc_r  <= lc_nxt;
      lne_r <= lne_nxt;
      tq_r  <= tq_nxt;
      ts_r  <= ts_nxt;
      hv_r  <= hv_nxt;
      hc_r  <= hc_nxt;
      tc_r  <= tc_nxt;
    end
  end

endmodule

FILE: sv/dct_result_buf.sv
// ----------------------------------------------------------------------------
// dct_result_buf: result buffer
// Takes up to three results in a cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module dct_result_buf #(
  parameter int LINE_COUNT_BITS  = dct_pkg::LINE_COUNT_BITS_DEF,
  parameter int TOKEN_COUNT_BITS = dct_pkg::TOKEN_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dct_pkg::push_t              push,
  input  logic [LINE_COUNT_BITS-1:0]  res_line,
  input  logic [TOKEN_COUNT_BITS-1:0] res_index,
  output logic                        space_ok,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_token_char,
  output logic                        out_token_last,
  output logic [LINE_COUNT_BITS-1:0]  out_line_number,
  output logic [TOKEN_COUNT_BITS-1:0] out_token_index
);

  dct_pkg::res_t                 ent_r  [dct_pkg::RDEPTH];
  logic [LINE_COUNT_BITS-1:0]    line_r [dct_pkg::RDEPTH];
  logic [TOKEN_COUNT_BITS-1:0]   idx_r  [dct_pkg::RDEPTH];
  logic [dct_pkg::RPTR_W-1:0]    wp_r;
  logic [dct_pkg::RPTR_W-1:0]    rp_r;
  logic [dct_pkg::RCNT_W-1:0]    cnt_r;
  logic                          pop;

  assign space_ok  = (cnt_r <= dct_pkg::RCNT_W'(dct_pkg::RDEPTH - dct_pkg::MAX_PUSH));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;

  assign out_kind        = ent_r[rp_r].kind;
  assign out_token_char  = ent_r[rp_r].ch;
  assign out_token_last  = ent_r[rp_r].last;
  assign out_line_number = line_r[rp_r];
  assign out_token_index = idx_r[rp_r];

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + dct_pkg::RPTR_W'(push.count);
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + dct_pkg::RCNT_W'(push.count) - dct_pkg::RCNT_W'(pop);
    end
  end

  // entry writes; line number is zero for end of input, index only on characters
  always_ff @(posedge clk) begin
    for (int i = 0; i < dct_pkg::MAX_PUSH; i++) begin
      if (2'(i) < push.count) begin
        ent_r[dct_pkg::RPTR_W'(wp_r + i)]  <= push.slot[i];
        line_r[dct_pkg::RPTR_W'(wp_r + i)] <=
          (push.slot[i].kind == dct_pkg::KIND_EOI) ? '0 : res_line;
        idx_r[dct_pkg::RPTR_W'(wp_r + i)]  <=
          (push.slot[i].kind == dct_pkg::KIND_TOKEN) ? res_index : '0;
      end
    end
  end

endmodule

FILE: sv/delimiter_class_tokenizer.sv
// ----------------------------------------------------------------------------
// delimiter_class_tokenizer: byte stream tokenizer with class table
// Cuts text into lines and tokens using loadable per-byte class bits.
// ----------------------------------------------------------------------------
// The block takes one item per clock unless it stalls: text bytes, end of
// input, class table writes and table clears. A text byte is looked up in
// the 256-entry class table in the cycle after it is accepted (registered
// table read), then passes a two-entry queue to the line and token stages,
// which handle one item per cycle while the result buffer has room and make
// up to three results. Results leave one per cycle from a four-entry buffer
// unless the receiver stalls, so the sustained rate is one item per cycle
// while items give at most one result each; an item with more results holds
// the output until all have left, and the token stages wait whenever the
// buffer has room for fewer than three. An item passes the lookup register
// and the queue, and its first result the result buffer, before showing. The
// table works straight after reset and after a clear, with no clearing pass.
module delimiter_class_tokenizer #(
  parameter int LINE_COUNT_BITS  = dct_pkg::LINE_COUNT_BITS_DEF,
  parameter int TOKEN_COUNT_BITS = dct_pkg::TOKEN_COUNT_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [7:0]                  in_data_byte,
  input  logic [3:0]                  in_class_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_kind,
  output logic [7:0]                  out_token_char,
  output logic                        out_token_last,
  output logic [LINE_COUNT_BITS-1:0]  out_line_number,
  output logic [TOKEN_COUNT_BITS-1:0] out_token_index
);

  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_valid;
  dct_pkg::item_t              q_in_item;
  dct_pkg::item_t              q_out_item;
  logic                        space_ok;
  dct_pkg::push_t              push;
  logic [LINE_COUNT_BITS-1:0]  res_line;
  logic [TOKEN_COUNT_BITS-1:0] res_index;

  // input side and class lookup
  dct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_class_bits (in_class_bits),
    .q_push        (q_push),
    .q_item        (q_in_item),
    .q_full        (q_full)
  );

  // item queue
  dct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (q_out_item)
  );

  // line and token stages
  dct_back #(
    .LINE_COUNT_BITS  (LINE_COUNT_BITS),
    .TOKEN_COUNT_BITS (TOKEN_COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_out_item),
    .space_ok  (space_ok),
    .q_pop     (q_pop),
    .push      (push),
    .res_line  (res_line),
    .res_index (res_index)
  );

  // result buffer
  dct_result_buf #(
    .LINE_COUNT_BITS  (LINE_COUNT_BITS),
    .TOKEN_COUNT_BITS (TOKEN_COUNT_BITS)
  ) u_rbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .res_line        (res_line),
    .res_index       (res_index),
    .space_ok        (space_ok),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_token_char  (out_token_char),
    .out_token_last  (out_token_last),
    .out_line_number (out_line_number),
    .out_token_index (out_token_index)
  );

  // nothing to deliver straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // the input only waits on a lookup that cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (q_full && !q_push))
    else $error("input stalled with room in the queue");

  // a token character always carries a one-based index
  a_token_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == dct_pkg::KIND_TOKEN) |-> (out_token_index != '0))
    else $error("token character without token index");

  // end of input reports a cleared line counter and no token fields
  a_eoi_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == dct_pkg::KIND_EOI) |->
      (out_line_number == '0 && out_token_index == '0 && out_token_char == 8'd0))
    else $error("end of input result with stale fields");

endmodule

FILE: tb/sv/delimiter_class_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// delimiter_class_tokenizer_tb: self-checking bench of the class tokenizer
// Drives text bytes, end of input, class table writes and clears through the
// input channel. A behavioural tokenizer inside the bench predicts each token
// character, line-ended and end-of-input event, and a checker compares every
// result item field by field. Random gaps and stalls on both channels, a long
// receiver hold-off and a full drain exercise the flow control.
// ----------------------------------------------------------------------------
module delimiter_class_tokenizer_tb;

  localparam int LCB        = dct_pkg::LINE_COUNT_BITS_DEF;
  localparam int TCB        = dct_pkg::TOKEN_COUNT_BITS_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int TAIL_WAIT  = 20;

  // class masks
  localparam logic [3:0] M_TERM  = 4'(1 << dct_pkg::CL_TERM);
  localparam logic [3:0] M_SKIP  = 4'(1 << dct_pkg::CL_SKIP);
  localparam logic [3:0] M_COMM  = 4'(1 << dct_pkg::CL_COMM);
  localparam logic [3:0] M_QUOTE = 4'(1 << dct_pkg::CL_QUOTE);

  // bytes used by the text streams
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef struct {
    logic [1:0]     kind;
    logic [7:0]     ch;
    logic           last;
    logic [LCB-1:0] line;
    logic [TCB-1:0] index;
  } token_event_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  dct_pkg::action_t in_action;
  logic [7:0]       in_data_byte;
  logic [3:0]       in_class_bits;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_kind;
  logic [7:0]       out_token_char;
  logic             out_token_last;
  logic [LCB-1:0]   out_line_number;
  logic [TCB-1:0]   out_token_index;

  // shadow tokenizer state
  logic [3:0]     class_map [256];
  logic [7:0]     line_quote;
  logic [7:0]     tok_quote;
  logic [1:0]     end_mode;
  logic [LCB-1:0] line_count;
  logic [TCB-1:0] tok_count;
  logic [7:0]     held_byte;
  bit             line_has_text;
  bit             tok_open;
  bit             held_full;

  token_event_t   expected_events [$];
  int             fail_count;
  int             sent_count;
  int             cycle_count;
  int             hold_left;
  bit             no_idle;

  delimiter_class_tokenizer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .in_class_bits   (in_class_bits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_token_char  (out_token_char),
    .out_token_last  (out_token_last),
    .out_line_number (out_line_number),
    .out_token_index (out_token_index)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // tokenizer prediction
  // ---------------------------------------------------------------------------
  function automatic void add_event(logic [1:0] kind, logic [7:0] ch, logic last,
                                    logic [TCB-1:0] index);
    token_event_t ev;
    ev.kind  = kind;
    ev.ch    = ch;
    ev.last  = last;
    ev.line  = line_count;
    ev.index = index;
    expected_events.push_back(ev);
  endfunction

  function automatic void reset_class_map();
    for (int i = 0; i < 256; i++) class_map[i] = 4'd0;
    class_map[dct_pkg::CH_NUL] = M_TERM;
  endfunction

  function automatic void bump_line();
    if (line_count != '1) line_count++;
  endfunction

  function automatic void close_line();
    if (held_full) add_event(dct_pkg::KIND_TOKEN, held_byte, 1'b1, tok_count);
    held_full     = 0;
    tok_open      = 0;
    tok_quote     = 8'd0;
    tok_count     = '0;
    line_quote    = 8'd0;
    line_has_text = 0;
    add_event(dct_pkg::KIND_LINE, 8'd0, 1'b0, '0);
  endfunction

  // token stage: skip, quote and terminator handling
  function automatic void token_stage(logic [7:0] c);
    logic [3:0] cl;
    bit         keep;
    cl = class_map[c];
    if (cl[dct_pkg::CL_QUOTE]) begin
      if (tok_quote == 8'd0) tok_quote = c;
      else if (c == tok_quote) tok_quote = 8'd0;
    end
    keep = !cl[dct_pkg::CL_SKIP] || (tok_quote != 8'd0 && tok_quote != c);
    if (keep) begin
      if (!tok_open) begin
        tok_open = 1;
        if (tok_count != '1) tok_count++;
      end
      if (held_full) add_event(dct_pkg::KIND_TOKEN, held_byte, 1'b0, tok_count);
      held_byte = c;
      held_full = 1;
    end
    if (tok_quote == 8'd0 && tok_open && cl[dct_pkg::CL_TERM]) begin
      if (held_full) add_event(dct_pkg::KIND_TOKEN, held_byte, 1'b1, tok_count);
      held_full = 0;
      tok_open  = 0;
    end
  endfunction

  // line stage: cr lf folding, comment tails, quoted line ends
  function automatic void line_stage(logic [7:0] b);
    logic [7:0] c;
    bit         lf_free;
    c       = b;
    lf_free = 0;
    if (end_mode == 2'd2) begin
      if (b == dct_pkg::CH_CR) end_mode = 2'd1;
      else if (b == dct_pkg::CH_LF) end_mode = 2'd0;
      return;
    end
    if (end_mode == 2'd1) begin
      end_mode = 2'd0;
      if (b == dct_pkg::CH_LF) begin
        if (line_quote == 8'd0) return;
        lf_free = 1;
      end
    end
    end_mode = 2'd0;
    if (c == dct_pkg::CH_NUL) begin
      // plain line end, not counted
    end else if (c == dct_pkg::CH_CR) begin
      bump_line();
      end_mode = 2'd1;
      if (line_quote == 8'd0) c = dct_pkg::CH_NUL;
    end else if (line_quote == 8'd0 && class_map[c][dct_pkg::CL_COMM]) begin
      bump_line();
      end_mode = 2'd2;
      c = dct_pkg::CH_NUL;
    end else if (c == dct_pkg::CH_LF) begin
      if (!lf_free) bump_line();
      if (line_quote == 8'd0) c = dct_pkg::CH_NUL;
    end
    if (c == dct_pkg::CH_NUL) begin
      close_line();
      return;
    end
    if (class_map[c][dct_pkg::CL_QUOTE]) begin
      if (line_quote == 8'd0) line_quote = c;
      else if (c == line_quote) line_quote = 8'd0;
    end
    line_has_text = 1;
    token_stage(c);
  endfunction

  function automatic void tokenize_item(dct_pkg::action_t act, logic [7:0] data,
                                        logic [3:0] bits);
    case (act)
      dct_pkg::ACT_TEXT: begin
        line_stage(data);
      end
      dct_pkg::ACT_EOI: begin
        if (line_has_text) begin
          if (end_mode == 2'd1) end_mode = 2'd0;
          close_line();
        end
        line_count = '0;
        add_event(dct_pkg::KIND_EOI, 8'd0, 1'b0, '0);
      end
      dct_pkg::ACT_OR_CLASS: begin
        class_map[data] = class_map[data] | bits;
      end
      default: begin
        reset_class_map();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    token_event_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual kind %0h char %0h",
                 $time, out_kind, out_token_char);
        fail_count++;
      end else begin
        want = expected_events.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("token_char", 32'(want.ch), 32'(out_token_char));
        check_field("token_last", 32'(want.last), 32'(out_token_last));
        check_field("line_number", 32'(want.line), 32'(out_line_number));
        check_field("token_index", 32'(want.index), 32'(out_token_index));
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, expected_events.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sending
  // ---------------------------------------------------------------------------
  // starts and ends at a falling edge; valid stays high for the next item
  task automatic send_item(input dct_pkg::action_t act, input logic [7:0] data,
                           input logic [3:0] bits);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_data_byte  <= data;
    in_class_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_item(act, data, bits);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(input logic [7:0] b);
    send_item(dct_pkg::ACT_TEXT, b, 4'($urandom));
  endtask

  task automatic send_eoi();
    send_item(dct_pkg::ACT_EOI, 8'($urandom), 4'($urandom));
  endtask

  // sender pause until every result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
  endtask

  // usual delimiter set on a freshly cleared table
  task automatic load_classes();
    send_item(dct_pkg::ACT_CLEAR, 8'($urandom), 4'($urandom));
    send_item(dct_pkg::ACT_OR_CLASS, CH_SPACE, M_SKIP | M_TERM);
    send_item(dct_pkg::ACT_OR_CLASS, CH_TAB, M_SKIP | M_TERM);
    send_item(dct_pkg::ACT_OR_CLASS, CH_COMMA, M_TERM);
    send_item(dct_pkg::ACT_OR_CLASS, CH_SEMI, M_TERM);
    send_item(dct_pkg::ACT_OR_CLASS, CH_HASH, M_COMM);
    send_item(dct_pkg::ACT_OR_CLASS, CH_DQUOTE, M_QUOTE);
    send_item(dct_pkg::ACT_OR_CLASS, CH_SQUOTE, M_QUOTE | M_SKIP);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 48) return 8'($urandom_range(122, 97));
    if (r < 58) return CH_SPACE;
    if (r < 66) return CH_COMMA;
    if (r < 70) return CH_SEMI;
    if (r < 75) return CH_DQUOTE;
    if (r < 78) return CH_SQUOTE;
    if (r < 81) return CH_HASH;
    if (r < 84) return CH_TAB;
    if (r < 87) return dct_pkg::CH_CR;
    if (r < 90) return dct_pkg::CH_LF;
    if (r < 92) return dct_pkg::CH_NUL;
    return 8'($urandom_range(255, 128));
  endfunction

  // one line of random content with a random way of ending it
  task automatic send_random_line();
    int len;
    len = $urandom_range(12, 1);
    repeat (len) send_text(pick_char());
    case ($urandom_range(6))
      0, 1: begin
        send_text(dct_pkg::CH_LF);
      end
      2: begin
        send_text(dct_pkg::CH_CR);
        send_text(dct_pkg::CH_LF);
      end
      3: begin
        send_text(dct_pkg::CH_CR);
      end
      4: begin
        send_text(dct_pkg::CH_NUL);
      end
      5: begin
        send_text(dct_pkg::CH_CR);
        send_eoi();
      end
      default: begin
        send_eoi();
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    load_classes();
    send_text("a");
    send_text(8'hFF);
    send_text(CH_COMMA);        // terminator kept as last char
    send_text(CH_SPACE);        // skipped
    send_text(CH_DQUOTE);
    send_text(CH_SPACE);        // skip char kept inside quotes
    send_text(dct_pkg::CH_CR);  // quoted cr is text
    send_text(dct_pkg::CH_LF);  // lf after quoted cr, not counted
    send_text(CH_DQUOTE);
    send_text(CH_HASH);         // comment ends line
    send_text("x");
    send_text(dct_pkg::CH_NUL); // dropped while flushing
    send_text(dct_pkg::CH_CR);
    send_text(dct_pkg::CH_LF);
    send_text("b");
    send_text(dct_pkg::CH_NUL); // line end without count
    send_text("c");
    send_text(dct_pkg::CH_CR);
    send_eoi();                 // cr already ended the line, so only end of input
    send_eoi();                 // empty line
    send_item(dct_pkg::ACT_OR_CLASS, dct_pkg::CH_NUL, 4'hF);
    send_text(dct_pkg::CH_NUL);
    send_item(dct_pkg::ACT_CLEAR, 8'hFF, 4'hF);
    send_text(CH_SPACE);        // plain char after clear
    send_text(dct_pkg::CH_LF);
  endtask

  // long line of one-character tokens, each its own terminator
  task automatic test_many_tokens();
    send_item(dct_pkg::ACT_CLEAR, 8'd0, 4'd0);
    send_item(dct_pkg::ACT_OR_CLASS, CH_COMMA, M_TERM);
    repeat (24) send_text(CH_COMMA);
    send_text(dct_pkg::CH_LF);
    send_eoi();
  endtask

  task automatic test_random_text(input int n);
    int target;
    int unsigned r;
    target = sent_count + n;
    load_classes();
    while (sent_count < target) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_random_line();
      end else if (r < 84) begin
        send_text(8'($urandom));
      end else if (r < 90) begin
        send_item(dct_pkg::ACT_OR_CLASS, 8'($urandom), 4'($urandom));
      end else if (r < 93) begin
        send_item(dct_pkg::ACT_OR_CLASS, pick_char(), 4'($urandom));
      end else if (r < 97) begin
        send_eoi();
      end else begin
        load_classes();
      end
    end
  endtask

  task automatic test_steady_stream();
    no_idle = 1;
    load_classes();
    repeat (8) send_random_line();
    no_idle = 0;
  endtask

  // receiver holds off while the sender offers text bytes, each followed by an end of input that gives three results
  task automatic test_backpressure();
    load_classes();
    hold_left = 150;
    repeat (20) begin
      send_text("q");
      send_eoi();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = dct_pkg::ACT_TEXT;
    in_data_byte  = 8'd0;
    in_class_bits = 4'd0;
    fail_count    = 0;
    sent_count    = 0;
    cycle_count   = 0;
    hold_left     = 0;
    no_idle       = 0;

    line_quote    = 8'd0;
    tok_quote     = 8'd0;
    end_mode      = 2'd0;
    line_count    = '0;
    tok_count     = '0;
    held_byte     = 8'd0;
    line_has_text = 0;
    tok_open      = 0;
    held_full     = 0;
    reset_class_map();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_many_tokens();
    test_random_text(70);
    test_steady_stream();
    test_backpressure();
    test_random_text(70);

    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
